// ===== design/umpbf_pkg.sv =====
// Shared types, codes and the code-index length table for the USB-MIDI
// packet to byte ring block. No dependencies.
`default_nettype none

package umpbf_pkg;

    // Stream widths (fields packed from bit 0, padded to whole bytes)
    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;
    localparam int FILL_W    = 10;

    // Result kinds
    localparam logic [1:0] KIND_PUSH  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_EMPTY = 2'd2;

    // Push status codes
    localparam logic [1:0] PS_STORED    = 2'd0;
    localparam logic [1:0] PS_ZERO_LEN  = 2'd1;
    localparam logic [1:0] PS_FULL      = 2'd2;
    localparam logic [1:0] PS_XFER_FAIL = 2'd3;

    // Which result the output register loads
    typedef enum logic [1:0] {
        SEL_PUSH,
        SEL_STORED,
        SEL_BYTE,
        SEL_EMPTY
    } out_sel_t;

    // Controller to datapath
    typedef struct packed {
        logic     load_item;
        logic     init_cnt;
        logic     wr_en;
        logic     rd_en;
        logic     load_out;
        logic     pop;
        out_sel_t out_sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic       is_read;
        logic [1:0] push_code;
        logic       read_none;
        logic       wr_last;
        logic       cnt_last;
        logic       out_free;
    } stat_t;

    // MIDI bytes carried by each code index
    function automatic logic [1:0] code_len(input logic [3:0] cin);
        logic [1:0] len;
        case (cin)
            4'h0, 4'h1:                      len = 2'd0;
            4'h5, 4'hF:                      len = 2'd1;
            4'h2, 4'h6, 4'hC, 4'hD:          len = 2'd2;
            default:                         len = 2'd3;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== design/usb_midi_packet_to_byte_fifo_core.sv =====
// Sequence: a push that stores is accepted, decoded, written one MIDI byte at a time
// into the ring, then loads its result; other pushes load their result at decode.
// Reads decode, then fetch each popped byte through the single registered read port
// and load it. One request in flight; results wait while the output is stalled.
// Reset (aresetn low, synchronous): positions, counters, state machine and result
// valid cleared, ring contents kept. Joins umpbf_ctrl, umpbf_datapath; umpbf_pkg.
`default_nettype none

module usb_midi_packet_to_byte_fifo_core #(
    parameter int RING_DEPTH = 512,
    parameter int MAX_READ   = 16
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [7:0] packet_header, [15:8] midi_byte_a, [23:16] midi_byte_b,
    // [31:24] midi_byte_c, [36:32] read_max, [39:37] zero
    input  wire logic [umpbf_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // [0] action, [1] transfer_ok
    input  wire logic [umpbf_pkg::S_TUSER_W-1:0]  s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [1:0] push_status, [3:2] bytes_stored, [11:4] byte_value,
    // [21:12] fill_level, [23:22] zero
    output logic [umpbf_pkg::M_TDATA_W-1:0]       m_axis_tdata,
    // [1:0] result_kind
    output logic [umpbf_pkg::M_TUSER_W-1:0]       m_axis_tuser,
    output logic                                  m_axis_tlast
);

    umpbf_pkg::cmd_t  cmd;
    umpbf_pkg::stat_t stat;

    logic [1:0]                     out_status;
    logic [1:0]                     out_stored;
    logic [7:0]                     out_value;
    logic [umpbf_pkg::FILL_W-1:0]   out_fill;
    logic [1:0]                     out_kind;

    umpbf_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    umpbf_datapath #(
        .RING_DEPTH (RING_DEPTH),
        .MAX_READ   (MAX_READ)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_action     (s_axis_tuser[0]),
        .in_xfer_ok    (s_axis_tuser[1]),
        .in_code       (s_axis_tdata[3:0]),
        .in_byte_a     (s_axis_tdata[15:8]),
        .in_byte_b     (s_axis_tdata[23:16]),
        .in_byte_c     (s_axis_tdata[31:24]),
        .in_read_max   (s_axis_tdata[36:32]),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tlast  (m_axis_tlast),
        .out_kind      (out_kind),
        .out_status    (out_status),
        .out_stored    (out_stored),
        .out_value     (out_value),
        .out_fill      (out_fill)
    );

    // Pack result fields
    assign m_axis_tdata = {2'b00, out_fill, out_value, out_stored, out_status};
    assign m_axis_tuser = out_kind;

endmodule

`default_nettype wire

// ===== design/umpbf_ctrl.sv =====
// Controller state machine for the USB-MIDI byte ring: sequences request
// decode, ring writes, ring reads and result loads. Uses umpbf_pkg.
`default_nettype none

module umpbf_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire umpbf_pkg::stat_t stat,
    output umpbf_pkg::cmd_t       cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECIDE    = 6'b000010,
        S_WRITE     = 6'b000100,
        S_PUSH_DONE = 6'b001000,
        S_RD_ADDR   = 6'b010000,
        S_RD_DATA   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Hold state, clear on reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.out_sel   = umpbf_pkg::SEL_PUSH;
        s_axis_tready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!stat.is_read) begin
                    if (stat.push_code == umpbf_pkg::PS_STORED) begin
                        state_next = S_WRITE;
                    end else if (stat.out_free) begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = umpbf_pkg::SEL_PUSH;
                        state_next   = S_IDLE;
                    end
                end else if (stat.read_none) begin
                    if (stat.out_free) begin
                        cmd.load_out = 1'b1;
                        cmd.out_sel  = umpbf_pkg::SEL_EMPTY;
                        state_next   = S_IDLE;
                    end
                end else begin
                    cmd.init_cnt = 1'b1;
                    state_next   = S_RD_ADDR;
                end
            end
            S_WRITE: begin
                cmd.wr_en = 1'b1;
                if (stat.wr_last) begin
                    state_next = S_PUSH_DONE;
                end
            end
            S_PUSH_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel  = umpbf_pkg::SEL_STORED;
                    state_next   = S_IDLE;
                end
            end
            S_RD_ADDR: begin
                cmd.rd_en  = 1'b1;
                state_next = S_RD_DATA;
            end
            S_RD_DATA: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.pop      = 1'b1;
                    cmd.out_sel  = umpbf_pkg::SEL_BYTE;
                    state_next   = stat.cnt_last ? S_IDLE : S_RD_ADDR;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/umpbf_datapath.sv =====
// Datapath for the USB-MIDI byte ring: request registers, ring memory,
// positions, fill arithmetic and the result register. Uses umpbf_pkg.
`default_nettype none

module umpbf_datapath #(
    parameter int RING_DEPTH = 512,
    parameter int MAX_READ   = 16
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               in_action,
    input  wire logic                               in_xfer_ok,
    input  wire logic [3:0]                         in_code,
    input  wire logic [7:0]                         in_byte_a,
    input  wire logic [7:0]                         in_byte_b,
    input  wire logic [7:0]                         in_byte_c,
    input  wire logic [4:0]                         in_read_max,
    input  wire umpbf_pkg::cmd_t                    cmd,
    output umpbf_pkg::stat_t                        stat,
    input  wire logic                               m_axis_tready,
    output logic                                    m_axis_tvalid,
    output logic                                    m_axis_tlast,
    output logic [1:0]                              out_kind,
    output logic [1:0]                              out_status,
    output logic [1:0]                              out_stored,
    output logic [7:0]                              out_value,
    output logic [umpbf_pkg::FILL_W-1:0]            out_fill
);

    localparam int POS_MOD = 2 * RING_DEPTH;
    localparam int PW      = $clog2(POS_MOD);
    localparam int AW      = $clog2(RING_DEPTH);
    localparam int CW      = $clog2(MAX_READ + 1);

    // Request registers
    logic          is_read_reg;
    logic          xfer_ok_reg;
    logic [3:0]    code_reg;
    logic [7:0]    byte_a_reg, byte_b_reg, byte_c_reg;
    logic [4:0]    read_max_reg;

    // Positions and counters
    logic [PW-1:0] wpos_reg, wpos_next;
    logic [PW-1:0] rpos_reg, rpos_next;
    logic [1:0]    widx_reg, widx_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Ring memory and read data
    logic [7:0]    ring_mem [RING_DEPTH];
    logic [7:0]    rd_data_reg;

    // Result register
    logic                          ovalid_reg, ovalid_next;
    logic                          olast_reg;
    logic [1:0]                    okind_reg, ostatus_reg, ostored_reg;
    logic [7:0]                    ovalue_reg;
    logic [umpbf_pkg::FILL_W-1:0]  ofill_reg;

    logic [1:0]    len;
    logic [PW:0]   diff;
    logic [PW-1:0] fill;
    logic [PW:0]   free_cnt;
    logic [1:0]    push_code;
    logic [CW-1:0] want;
    logic [CW-1:0] nread;
    logic [AW-1:0] wr_idx, rd_idx;
    logic [7:0]    wr_byte;
    logic          out_free;

    // Fill is the position difference modulo twice the depth
    assign diff = {1'b0, wpos_reg} - {1'b0, rpos_reg};
    assign fill = diff[PW] ? PW'(diff + (PW+1)'(POS_MOD)) : diff[PW-1:0];
    assign free_cnt = (PW+1)'(RING_DEPTH) - {1'b0, fill};

    // Decide the push outcome
    assign len = umpbf_pkg::code_len(code_reg);
    always_comb begin
        if (!xfer_ok_reg) begin
            push_code = umpbf_pkg::PS_XFER_FAIL;
        end else if (len == 2'd0) begin
            push_code = umpbf_pkg::PS_ZERO_LEN;
        end else if ((PW+1)'(len) > free_cnt) begin
            push_code = umpbf_pkg::PS_FULL;
        end else begin
            push_code = umpbf_pkg::PS_STORED;
        end
    end

    // Saturate the read limit, then clip to what the ring holds
    assign want  = (32'(read_max_reg) > 32'(MAX_READ)) ? CW'(MAX_READ) : CW'(read_max_reg);
    assign nread = (32'(fill) < 32'(want)) ? CW'(fill) : want;

    // Ring addresses: position folded once into the depth
    assign wr_idx = (wpos_reg >= PW'(RING_DEPTH)) ? AW'(wpos_reg - PW'(RING_DEPTH))
                                                  : AW'(wpos_reg);
    assign rd_idx = (rpos_reg >= PW'(RING_DEPTH)) ? AW'(rpos_reg - PW'(RING_DEPTH))
                                                  : AW'(rpos_reg);

    always_comb begin
        case (widx_reg)
            2'd0:    wr_byte = byte_a_reg;
            2'd1:    wr_byte = byte_b_reg;
            default: wr_byte = byte_c_reg;
        endcase
    end

    assign out_free = !ovalid_reg || m_axis_tready;

    // Status back to the controller
    always_comb begin
        stat           = '0;
        stat.is_read   = is_read_reg;
        stat.push_code = push_code;
        stat.read_none = (nread == '0);
        stat.wr_last   = (widx_reg == (len - 2'd1));
        stat.cnt_last  = (cnt_reg == CW'(1));
        stat.out_free  = out_free;
    end

    // Latch an accepted request
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            is_read_reg  <= in_action;
            xfer_ok_reg  <= in_xfer_ok;
            code_reg     <= in_code;
            byte_a_reg   <= in_byte_a;
            byte_b_reg   <= in_byte_b;
            byte_c_reg   <= in_byte_c;
            read_max_reg <= in_read_max;
        end
    end

    // Advance positions and counters
    always_comb begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        widx_next = widx_reg;
        cnt_next  = cnt_reg;
        if (cmd.load_item) begin
            widx_next = 2'd0;
        end
        if (cmd.wr_en) begin
            wpos_next = (wpos_reg == PW'(POS_MOD - 1)) ? '0 : wpos_reg + PW'(1);
            widx_next = widx_reg + 2'd1;
        end
        if (cmd.init_cnt) begin
            cnt_next = nread;
        end
        if (cmd.pop) begin
            rpos_next = (rpos_reg == PW'(POS_MOD - 1)) ? '0 : rpos_reg + PW'(1);
            cnt_next  = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpos_reg <= '0;
            rpos_reg <= '0;
            widx_reg <= 2'd0;
            cnt_reg  <= '0;
        end else begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
            widx_reg <= widx_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Ring memory: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            ring_mem[wr_idx] <= wr_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= ring_mem[rd_idx];
        end
    end

    // Result register valid
    always_comb begin
        ovalid_next = ovalid_reg;
        if (cmd.load_out) begin
            ovalid_next = 1'b1;
        end else if (m_axis_tready) begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
        end else begin
            ovalid_reg <= ovalid_next;
        end
    end

    // Load result fields
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            okind_reg   <= umpbf_pkg::KIND_PUSH;
            ostatus_reg <= umpbf_pkg::PS_STORED;
            ostored_reg <= 2'd0;
            ovalue_reg  <= 8'd0;
            ofill_reg   <= umpbf_pkg::FILL_W'(fill);
            olast_reg   <= 1'b1;
            case (cmd.out_sel)
                umpbf_pkg::SEL_PUSH: begin
                    ostatus_reg <= push_code;
                end
                umpbf_pkg::SEL_STORED: begin
                    ostored_reg <= len;
                end
                umpbf_pkg::SEL_BYTE: begin
                    okind_reg  <= umpbf_pkg::KIND_BYTE;
                    ovalue_reg <= rd_data_reg;
                    ofill_reg  <= umpbf_pkg::FILL_W'(fill - PW'(1));
                    olast_reg  <= (cnt_reg == CW'(1));
                end
                default: begin
                    okind_reg <= umpbf_pkg::KIND_EMPTY;
                end
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tlast  = olast_reg;
    assign out_kind      = okind_reg;
    assign out_status    = ostatus_reg;
    assign out_stored    = ostored_reg;
    assign out_value     = ovalue_reg;
    assign out_fill      = ofill_reg;

endmodule

`default_nettype wire

// ===== design/umpbf_checker.sv =====
// Port-level checks for the USB-MIDI byte ring top level, bound to it below.
// Uses umpbf_pkg for the result codes.
`default_nettype none

module umpbf_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_axis_tvalid,
    input wire logic                             m_axis_tready,
    input wire logic [umpbf_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input wire logic [umpbf_pkg::M_TUSER_W-1:0]  m_axis_tuser,
    input wire logic                             m_axis_tlast
);

    // Reset empties the result register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A stalled result stays offered
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped under stall");

    // Push and empty-read results are single and so always last
    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && (m_axis_tuser == umpbf_pkg::KIND_PUSH ||
                          m_axis_tuser == umpbf_pkg::KIND_EMPTY) |-> m_axis_tlast)
        else $error("single result without last");

    // Read results carry no push status
    a_read_no_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != umpbf_pkg::KIND_PUSH |->
            m_axis_tdata[3:0] == 4'd0)
        else $error("read result with push fields");

endmodule

bind usb_midi_packet_to_byte_fifo_core umpbf_checker u_umpbf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== test/tb_usb_midi_packet_to_byte_fifo_core.sv =====
// Self-checking bench for usb_midi_packet_to_byte_fifo_core: drives event-packet pushes
// and byte reads on the request stream and checks every result against a ring predictor.
// Depends on umpbf_pkg and the block under test only.
`default_nettype none

module tb_usb_midi_packet_to_byte_fifo_core;

    localparam int RING_BYTES    = 512;
    localparam int READ_CAP      = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 50;
    localparam int N_DIRECTED    = 25;

    localparam int STYLE_MIX   = 0;
    localparam int STYLE_FILL  = 1;
    localparam int STYLE_DRAIN = 2;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // MIDI bytes carried by each code index
    localparam logic [1:0] MIDI_BYTES_PER_CIN [16] = '{
        2'd0, 2'd0, 2'd2, 2'd3, 2'd3, 2'd1, 2'd2, 2'd3,
        2'd3, 2'd3, 2'd3, 2'd3, 2'd2, 2'd2, 2'd3, 2'd1
    };
    // Code indexes that carry three bytes, used to fill the ring quickly
    localparam logic [3:0] LONG_CINS [8] = '{
        4'h3, 4'h4, 4'h7, 4'h8, 4'h9, 4'hA, 4'hB, 4'hE
    };

    typedef struct packed {
        logic       action;
        logic       xfer_ok;
        logic [7:0] header;
        logic [7:0] byte_a;
        logic [7:0] byte_b;
        logic [7:0] byte_c;
        logic [4:0] read_max;
    } midi_req_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] status;
        logic [1:0] stored;
        logic [7:0] value;
        logic [9:0] fill;
        logic       last;
    } midi_res_t;

    typedef struct packed {
        midi_req_t rq;
        logic      typed;
        midi_res_t res;
    } directed_row_t;

    typedef struct packed {
        logic      typed;
        midi_res_t res;
    } row_check_t;

    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [umpbf_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [umpbf_pkg::S_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [umpbf_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic [umpbf_pkg::M_TUSER_W-1:0]  m_axis_tuser;
    logic                             m_axis_tlast;

    // Predictor state
    logic [7:0] ring_copy [RING_BYTES];
    logic [9:0] ring_wr = '0;
    logic [9:0] ring_rd = '0;

    midi_res_t     expected_results [$];
    row_check_t    row_checks [$];
    directed_row_t directed_rows [N_DIRECTED];

    int sender_idle_pct = 0;
    int rx_stall_pct    = 0;
    int hold_seq        = 0;
    int hold_seen       = 0;
    int hold_left       = 0;
    int quiet_cycles    = 0;
    int mismatch_count  = 0;

    // Run statistics
    int n_requests   = 0;
    int n_stored     = 0;
    int n_full_drops = 0;
    int n_popped     = 0;
    int n_empty      = 0;
    int peak_fill    = 0;

    usb_midi_packet_to_byte_fifo_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic midi_req_t mk_req(input logic act, input logic ok,
                                         input logic [7:0] hdr,
                                         input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c, input logic [4:0] rmax);
        midi_req_t rq;
        rq = '{act, ok, hdr, a, b, c, rmax};
        return rq;
    endfunction

    function automatic midi_res_t mk_res(input logic [1:0] kind, input logic [1:0] status,
                                         input logic [1:0] stored, input logic [7:0] value,
                                         input logic [9:0] fill, input logic last);
        midi_res_t r;
        r = '{kind, status, stored, value, fill, last};
        return r;
    endfunction

    // Work out the results of one accepted request and advance the ring copy
    function automatic void predict_request(input midi_req_t rq);
        int          nbytes;
        int          fill;
        int          want;
        int          npop;
        logic [23:0] payload;
        fill = int'(10'(ring_wr - ring_rd));
        n_requests++;
        if (rq.action == ACT_PUSH) begin
            nbytes  = MIDI_BYTES_PER_CIN[rq.header[3:0]];
            payload = {rq.byte_c, rq.byte_b, rq.byte_a};
            if (!rq.xfer_ok) begin
                expected_results.push_back(mk_res(umpbf_pkg::KIND_PUSH,
                                                  umpbf_pkg::PS_XFER_FAIL, '0, '0,
                                                  10'(fill), 1'b1));
            end else if (nbytes == 0) begin
                expected_results.push_back(mk_res(umpbf_pkg::KIND_PUSH,
                                                  umpbf_pkg::PS_ZERO_LEN, '0, '0,
                                                  10'(fill), 1'b1));
            end else if (nbytes > RING_BYTES - fill) begin
                n_full_drops++;
                expected_results.push_back(mk_res(umpbf_pkg::KIND_PUSH,
                                                  umpbf_pkg::PS_FULL, '0, '0,
                                                  10'(fill), 1'b1));
            end else begin
                for (int i = 0; i < nbytes; i++)
                    ring_copy[9'(ring_wr + 10'(i))] = payload[8*i +: 8];
                ring_wr = ring_wr + 10'(nbytes);
                fill    = fill + nbytes;
                n_stored++;
                if (fill > peak_fill)
                    peak_fill = fill;
                expected_results.push_back(mk_res(umpbf_pkg::KIND_PUSH,
                                                  umpbf_pkg::PS_STORED, 2'(nbytes), '0,
                                                  10'(fill), 1'b1));
            end
        end else begin
            want = (rq.read_max > READ_CAP) ? READ_CAP : int'(rq.read_max);
            npop = (fill < want) ? fill : want;
            if (npop == 0) begin
                n_empty++;
                expected_results.push_back(mk_res(umpbf_pkg::KIND_EMPTY, '0, '0, '0,
                                                  10'(fill), 1'b1));
            end else begin
                for (int i = 0; i < npop; i++) begin
                    fill--;
                    expected_results.push_back(mk_res(umpbf_pkg::KIND_BYTE, '0, '0,
                                                      ring_copy[9'(ring_rd)],
                                                      10'(fill), (i == npop - 1)));
                    ring_rd = ring_rd + 10'd1;
                end
                n_popped += npop;
            end
        end
    endfunction

    function automatic void compare_field(input string fname, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            mismatch_count++;
        end
    endfunction

    // Predict on each accepted request, check each accepted result, count quiet cycles
    always @(posedge aclk) begin : stream_monitor
        midi_req_t  rq;
        row_check_t rc;
        midi_res_t  want;
        logic       moved;
        moved = 1'b0;
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            moved       = 1'b1;
            rq.action   = s_axis_tuser[0];
            rq.xfer_ok  = s_axis_tuser[1];
            rq.header   = s_axis_tdata[7:0];
            rq.byte_a   = s_axis_tdata[15:8];
            rq.byte_b   = s_axis_tdata[23:16];
            rq.byte_c   = s_axis_tdata[31:24];
            rq.read_max = s_axis_tdata[36:32];
            rc = row_checks.pop_front();
            predict_request(rq);
            // Replace the prediction by the typed-in answer on directed rows that carry one
            if (rc.typed) begin
                void'(expected_results.pop_back());
                expected_results.push_back(rc.res);
            end
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            moved = 1'b1;
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: kind %0d data %h last %0d",
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("result_kind", want.kind, m_axis_tuser);
                compare_field("push_status", want.status, m_axis_tdata[1:0]);
                compare_field("bytes_stored", want.stored, m_axis_tdata[3:2]);
                compare_field("byte_value", want.value, m_axis_tdata[11:4]);
                compare_field("fill_level", want.fill, m_axis_tdata[21:12]);
                compare_field("last", want.last, m_axis_tlast);
            end
        end
        quiet_cycles <= (!aresetn || moved) ? 0 : quiet_cycles + 1;
    end

    // Result sink: long hold on request, otherwise random stalls
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_seq != hold_seen) begin
            m_axis_tready <= 1'b0;
            hold_seen     <= hold_seq;
            hold_left     <= LONG_HOLD;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Abort when nothing moves on either side for too long
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge aclk);
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected_results.size());
        $display("status: fail");
        $finish;
    end

    // Offer one request, with random idle cycles ahead of it, and hold until taken
    task automatic send_request(input midi_req_t rq, input logic typed, input midi_res_t res);
        row_check_t rc;
        rc.typed = typed;
        rc.res   = res;
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        row_checks.push_back(rc);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, rq.read_max, rq.byte_c, rq.byte_b, rq.byte_a, rq.header};
        s_axis_tuser  <= {rq.xfer_ok, rq.action};
        do @(posedge aclk); while (!s_axis_tready);
    endtask

    // Drop valid and wait until every outstanding result has been taken
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_results.size() != 0);
    endtask

    task automatic run_random(input int count, input int style);
        midi_req_t rq;
        for (int k = 0; k < count; k++) begin
            rq.header   = 8'($urandom_range(255));
            rq.byte_a   = 8'($urandom_range(255));
            rq.byte_b   = 8'($urandom_range(255));
            rq.byte_c   = 8'($urandom_range(255));
            rq.read_max = 5'($urandom_range(31));
            rq.xfer_ok  = ($urandom_range(11) != 0);
            case (style)
                STYLE_MIX: begin
                    rq.action = 1'($urandom_range(1));
                end
                STYLE_FILL: begin
                    rq.action = ACT_PUSH;
                    if ($urandom_range(9) != 0)
                        rq.header[3:0] = LONG_CINS[3'($urandom_range(7))];
                end
                default: begin
                    rq.action = ($urandom_range(9) != 0) ? ACT_READ : ACT_PUSH;
                end
            endcase
            if (rq.action == ACT_READ) begin
                if (style == STYLE_DRAIN) begin
                    rq.read_max = 5'($urandom_range(31, 8));
                end else begin
                    case ($urandom_range(9))
                        0:       rq.read_max = '0;
                        1:       rq.read_max = 5'($urandom_range(31, 17));
                        default: rq.read_max = 5'($urandom_range(16, 1));
                    endcase
                end
            end
            send_request(rq, 1'b0, '0);
        end
    endtask

    initial begin
        // Directed rows: empty ring, failed transfer, zero-length codes, codes 2 to F, reads
        directed_rows[0] = '{mk_req(ACT_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 5'd4), 1'b1,
                             mk_res(umpbf_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1)};
        directed_rows[1] = '{mk_req(ACT_PUSH, 1'b0, 8'h39, 8'h90, 8'h3C, 8'h7F, 5'd0), 1'b1,
                             mk_res(umpbf_pkg::KIND_PUSH, umpbf_pkg::PS_XFER_FAIL,
                                    '0, '0, '0, 1'b1)};
        directed_rows[2] = '{mk_req(ACT_PUSH, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd31), 1'b1,
                             mk_res(umpbf_pkg::KIND_PUSH, umpbf_pkg::PS_ZERO_LEN,
                                    '0, '0, '0, 1'b1)};
        directed_rows[3] = '{mk_req(ACT_PUSH, 1'b1, 8'hF1, 8'h12, 8'h34, 8'h56, 5'd16), 1'b1,
                             mk_res(umpbf_pkg::KIND_PUSH, umpbf_pkg::PS_ZERO_LEN,
                                    '0, '0, '0, 1'b1)};
        directed_rows[4] = '{mk_req(ACT_PUSH, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 5'd0), 1'b1,
                             mk_res(umpbf_pkg::KIND_PUSH, umpbf_pkg::PS_XFER_FAIL,
                                    '0, '0, '0, 1'b1)};
        directed_rows[5] = '{mk_req(ACT_READ, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h00, 5'd0), 1'b1,
                             mk_res(umpbf_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1)};
        directed_rows[6] = '{mk_req(ACT_READ, 1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 5'd31), 1'b1,
                             mk_res(umpbf_pkg::KIND_EMPTY, '0, '0, '0, '0, 1'b1)};
        for (int i = 0; i < 14; i++) begin
            if (i % 2 == 0)
                directed_rows[7 + i] = '{mk_req(ACT_PUSH, 1'b1, {4'(15 - i), 4'(i + 2)},
                                                8'h00, 8'hFF, 8'h80, 5'(i)), 1'b0, '0};
            else
                directed_rows[7 + i] = '{mk_req(ACT_PUSH, 1'b1, {4'(15 - i), 4'(i + 2)},
                                                8'hFF, 8'h00, 8'h7F, 5'(i)), 1'b0, '0};
        end
        directed_rows[21] = '{mk_req(ACT_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 5'd0),
                              1'b0, '0};
        directed_rows[22] = '{mk_req(ACT_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 5'd31),
                              1'b0, '0};
        directed_rows[23] = '{mk_req(ACT_READ, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 5'd16),
                              1'b0, '0};
        directed_rows[24] = '{mk_req(ACT_READ, 1'b1, 8'h00, 8'h00, 8'h00, 8'h00, 5'd1),
                              1'b0, '0};

        // Hold reset low, then release it
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].res);

        // Mixed traffic, no idling
        run_random(40, STYLE_MIX);

        // Mixed traffic, sender mostly idle
        sender_idle_pct = 81;
        run_random(40, STYLE_MIX);

        // Receiver mostly stalled, with one long hold while requests keep coming
        sender_idle_pct = 0;
        rx_stall_pct   <= 81;
        hold_seq       <= hold_seq + 1;
        run_random(40, STYLE_MIX);

        // Pause the sender until the block has drained
        wait_for_results();

        // Fill the ring past full with both sides idling now and then
        sender_idle_pct = 29;
        rx_stall_pct   <= 29;
        run_random(200, STYLE_FILL);

        // Drain the ring with wide reads, no idling
        sender_idle_pct = 0;
        rx_stall_pct   <= 0;
        run_random(45, STYLE_DRAIN);

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d stored pushes, %0d dropped on a full ring,",
                 n_requests, n_stored, n_full_drops);
        $display("%0d bytes read back, %0d empty reads, peak fill %0d of %0d",
                 n_popped, n_empty, peak_fill, RING_BYTES);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
